>>> rtl/two_way_hashed_result_cache_core_defines.svh
// Assertion macros for the hashed result cache core.
// No dependencies; included by files that assert.
`ifndef TWO_WAY_HASHED_RESULT_CACHE_CORE_DEFINES_SVH
`define TWO_WAY_HASHED_RESULT_CACHE_CORE_DEFINES_SVH
`ifndef SYNTH
`define AST_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("impl");
`define AST_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("next");
`else
`define AST_IMPL(label, clk, rst, a, c)
`define AST_NEXT(label, clk, rst, a, c)
`endif
`endif

>>> rtl/thrc_pkg.sv
// Shared types and constants of the hashed result cache.
// No dependencies.
package thrc_pkg;
  localparam int MAX_INDEX_BITS_DEF = 12;
  localparam int KEY_WORDS = 7;
  localparam logic [31:0] HASH_SEED = 32'hdeadbeef;
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // one step of the hash unit: x = (x op1 y) op2 rotl(z, r); w += v
  typedef enum logic [1:0] {OP_SUB_XOR = 2'd0, OP_XOR_SUB = 2'd1, OP_ADD = 2'd2} hop_t;
  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
    logic [63:0] d;
    d = {x, x} << k;
    return d[63:32];
  endfunction
endpackage

>>> rtl/thrc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module thrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> rtl/thrc_hash.sv
// Iterative lookup3-style hash: one rotate/add/xor step per cycle.
// Depends on thrc_pkg and the core defines header.
`include "two_way_hashed_result_cache_core_defines.svh"
module thrc_hash import thrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] k [KEY_WORDS],
  input  logic [30:0] ctx,
  output logic        done,
  output logic [31:0] hash
);
  // step table: 0 load, mix (6 steps x 2 ops) etc; encoded by counter
  logic [31:0] a, b, c;
  logic [5:0]  step;
  logic        run;
  logic [31:0] sa, sb, sc;
  logic [31:0] seed;
  // ctx is only sampled on go
  assign seed = HASH_SEED + {1'b0, ctx};
  assign hash = c;

  // per step: dst (0 a,1 b,2 c), src y, rot src z, r, op
  function automatic logic [4:0] mrot(input logic [2:0] i);
    unique case (i)
      3'd0: return 5'd4;  3'd1: return 5'd6;  3'd2: return 5'd8;
      3'd3: return 5'd16; 3'd4: return 5'd19; default: return 5'd4;
    endcase
  endfunction
  function automatic logic [4:0] frot(input logic [2:0] i);
    unique case (i)
      3'd0: return 5'd14; 3'd1: return 5'd11; 3'd2: return 5'd25;
      3'd3: return 5'd16; 3'd4: return 5'd4;  3'd5: return 5'd14;
      default: return 5'd24;
    endcase
  endfunction
  // target register of a round step: 0 a/c, 1 b/a, 2 c/b
  function automatic logic [1:0] mod3(input logic [2:0] i);
    unique case (i)
      3'd0, 3'd3, 3'd6: return 2'd0;
      3'd1, 3'd4, 3'd7: return 2'd1;
      default: return 2'd2;
    endcase
  endfunction

  // steps: 0 add k0..2; 1..6 mix; 7 add k3..5; 8..13 mix; 14 add k6; 15..21 final
  logic [2:0]  mi;
  logic [1:0]  mm;
  logic [31:0] x, y, xn, w, wn;
  logic [4:0]  r;
  always_comb begin
    sa = a; sb = b; sc = c;
    mi = 3'd0; x = a; y = c; w = c; r = 5'd0;
    if (step >= 6'd15) mi = 3'(step - 6'd15);
    else if (step >= 6'd8) mi = 3'(step - 6'd8);
    else mi = 3'(step - 6'd1);
    mm = mod3(mi);
    // mix rounds cycle targets a,b,c: x -= y; x ^= rotl(y); y += w
    unique case (mm)
      2'd0: begin x = a; y = c; w = b; end
      2'd1: begin x = b; y = a; w = c; end
      default: begin x = c; y = b; w = a; end
    endcase
    r = mrot(mi);
    xn = (x - y) ^ rotl(y, r);
    wn = y + w;
    if (step == 6'd0) begin
      sa = a + k[0]; sb = b + k[1]; sc = c + k[2];
    end else if (step == 6'd7) begin
      sa = a + k[3]; sb = b + k[4] + k[5];
    end else if (step == 6'd14) begin
      sa = a + k[6];
    end else if (step >= 6'd15) begin
      // final: c^=b,-rot(b); a^=c; b^=a; ...
      unique case (mm)
        2'd0: begin x = c; y = b; end
        2'd1: begin x = a; y = c; end
        default: begin x = b; y = a; end
      endcase
      xn = (x ^ y) - rotl(y, frot(mi));
      unique case (mm)
        2'd0: sc = xn;
        2'd1: sa = xn;
        default: sb = xn;
      endcase
    end else begin
      unique case (mm)
        2'd0: begin sa = xn; sc = wn; end
        2'd1: begin sb = xn; sa = wn; end
        default: begin sc = xn; sb = wn; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0; step <= '0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1; step <= '0;
      end else if (run) begin
        step <= step + 6'd1;
        if (step == 6'd21) begin
          run <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (go) begin
      a <= seed; b <= seed; c <= seed;
    end else if (run) begin
      a <= sa; b <= sb; c <= sc;
    end
  end

  `AST_NEXT(a_done_ends, clk, rst, done, !run)
  `AST_IMPL(a_step_rng, clk, rst, run, step <= 6'd21)
  `AST_NEXT(a_go_runs, clk, rst, go, run && step == 6'd0)
endmodule

>>> rtl/two_way_hashed_result_cache_core.sv
// Two-way hashed result cache. A lookup runs 22 hash steps in the rotate/add/xor unit,
// then set read, compare, update; an add skips the hash, an unused request goes
// straight to its result; a flush clears one set per cycle.
// busy is high while an item is in work; one result strobe per item, one item at a time.
// Synchronous reset runs the valid clearing pass and keeps busy high through it.
// Receiver cannot stall: results appear for one cycle on done.
module two_way_hashed_result_cache_core import thrc_pkg::*; #(
  parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] key_w01,
  input  logic [63:0] key_w23,
  input  logic [63:0] key_w45,
  input  logic [31:0] key_w6,
  input  logic [30:0] context_req,
  input  logic [11:0] slot_index,
  input  logic [63:0] payload_lo,
  input  logic [63:0] payload_mid,
  input  logic [63:0] payload_hi,
  output logic        done,
  output logic        hit,
  output logic [11:0] set_index,
  output logic [63:0] data_lo,
  output logic [63:0] data_mid,
  output logic [63:0] data_hi,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int NSETS = 1 << MAX_INDEX_BITS;
  localparam int SI = MAX_INDEX_BITS;
  // entry: valid, context, key, payload
  localparam int EW = 1 + 31 + 32 * KEY_WORDS + 192;

  typedef enum logic [6:0] {
    S_CLR = 7'b0000001, S_IDLE = 7'b0000010, S_HASH = 7'b0000100,
    S_RD = 7'b0001000, S_WAIT = 7'b0010000, S_CMP = 7'b0100000,
    S_OUT = 7'b1000000
  } st_t;
  st_t st;

  logic [3:0] index_bits;
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {28'd0, index_bits} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) index_bits <= 4'd12;
    else if (psel && penable && pwrite && paddr == 1'b0) index_bits <= pwdata[3:0];
  end
  logic [SI-1:0] mask;
  always_comb begin
    logic [4:0] bits;
    bits = ({1'b0, index_bits} > 5'(SI)) ? 5'(SI) : {1'b0, index_bits};
    mask = SI'((33'd1 << bits) - 33'd1);
  end

  // captured request
  logic [1:0]  rq;
  logic [31:0] k [KEY_WORDS];
  logic [30:0] ctx;
  logic [SI-1:0] set;
  logic [191:0] pay;
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ctx <= context_req; pay <= {payload_hi, payload_mid, payload_lo};
      k[0] <= key_w01[31:0]; k[1] <= key_w01[63:32];
      k[2] <= key_w23[31:0]; k[3] <= key_w23[63:32];
      k[4] <= key_w45[31:0]; k[5] <= key_w45[63:32];
      k[6] <= key_w6;
    end
  end

  // seed is taken from the context on the port at the accepting edge
  logic hgo, hdone;
  logic [31:0] hval;
  thrc_hash u_hash (.clk, .rst, .go(hgo), .k, .ctx(context_req), .done(hdone), .hash(hval));

  // ways: entry valid bit lives in the RAM word; clear pass resets it
  logic          we0, we1, psel_we;
  logic [SI-1:0] addr;
  logic [EW-1:0] wd0, wd1, rd0, rd1, ent;
  logic          psel_rd, psel_wd;
  thrc_ram #(.WIDTH(EW), .DEPTH(NSETS)) u_w0 (.clk, .we(we0), .addr, .wdata(wd0), .rdata(rd0));
  thrc_ram #(.WIDTH(EW), .DEPTH(NSETS)) u_w1 (.clk, .we(we1), .addr, .wdata(wd1), .rdata(rd1));
  thrc_ram #(.WIDTH(1), .DEPTH(NSETS)) u_sel (.clk, .we(psel_we), .addr, .wdata(psel_wd),
                                               .rdata(psel_rd));

  logic [SI:0] cnt;
  logic        m0, m1;
  assign ent = {1'b1, ctx, k[6], k[5], k[4], k[3], k[2], k[1], k[0], pay};
  function automatic logic match(input logic [EW-1:0] e, input logic [EW-1:0] q);
    return e[EW-1] && (e[EW-2:192] == q[EW-2:192]);
  endfunction
  assign m0 = match(psel_rd ? rd1 : rd0, ent);
  assign m1 = match(psel_rd ? rd0 : rd1, ent);

  always_comb begin
    we0 = 1'b0; we1 = 1'b0; psel_we = 1'b0; psel_wd = psel_rd;
    wd0 = ent; wd1 = ent; hgo = 1'b0;
    addr = set;
    if (st == S_CLR) begin
      addr = cnt[SI-1:0]; we0 = 1'b1; we1 = 1'b1; wd0 = '0; wd1 = '0;
      // clear pass after reset also clears way select; flush keeps it
      psel_we = (rq != REQ_FLUSH); psel_wd = 1'b0;
    end else if (st == S_IDLE) begin
      hgo = start && req_type == REQ_LOOKUP;
    end else if (st == S_CMP) begin
      if (rq == REQ_LOOKUP) begin
        psel_we = !m0 && m1; psel_wd = !psel_rd;
      end else begin
        psel_we = 1'b1; psel_wd = !psel_rd;
        we0 = psel_rd; we1 = !psel_rd;
      end
    end
  end
  // clear pass zeroes whole entries

  always_ff @(posedge clk) begin
    if (rst) begin
      // reset pass runs with rq at lookup: clears way select, no strobe at its end
      st <= S_CLR; cnt <= '0; done <= 1'b0; rq <= REQ_LOOKUP;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (SI+1)'(NSETS - 1)) st <= S_OUT;
        end
        S_IDLE: if (start) begin
          cnt <= '0;
          if (req_type == REQ_LOOKUP) st <= S_HASH;
          else if (req_type == REQ_ADD) begin
            set <= SI'(slot_index) & mask; st <= S_RD;
          end else if (req_type == REQ_FLUSH) st <= S_CLR;
          else st <= S_OUT;
        end
        S_HASH: if (hdone) begin set <= hval[SI-1:0] & mask; st <= S_RD; end
        S_RD:   st <= S_WAIT;
        S_WAIT: st <= S_CMP;
        S_CMP: begin
          done <= 1'b1;
          hit <= (rq == REQ_LOOKUP) && (m0 || m1);
          set_index <= 12'(set);
          {data_hi, data_mid, data_lo} <= (rq != REQ_LOOKUP) ? 192'd0 :
            m0 ? (psel_rd ? rd1[191:0] : rd0[191:0]) :
            m1 ? (psel_rd ? rd0[191:0] : rd1[191:0]) : 192'd0;
          st <= S_IDLE;
        end
        S_OUT: begin
          // flush / unused request / end of reset pass
          done <= (rq != REQ_LOOKUP);
          hit <= 1'b0; set_index <= '0;
          {data_hi, data_mid, data_lo} <= '0;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
      if (st == S_IDLE && start) rq <= req_type;
    end
  end
  assign busy = (st != S_IDLE);
endmodule

>>> test/tb.sv
// Testbench for two_way_hashed_result_cache_core: directed and random requests,
// checked against an in-bench model of the hashed two-way cache.
// Depends on thrc_pkg and the core RTL.
module tb;
  import thrc_pkg::*;

  // model of one result transfer
  typedef struct packed {
    logic        hit;
    logic [11:0] set_index;
    logic [63:0] data_lo;
    logic [63:0] data_mid;
    logic [63:0] data_hi;
  } cache_resp_t;

  // model of the cache contents and the expected-response queue
  class cache_scoreboard;
    logic [3:0]  idx_bits;
    bit          valid[8192];
    bit          psel_bit[4096];
    logic [31:0] keys[8192][7];
    logic [30:0] ctxs[8192];
    logic [63:0] pay[8192][3];
    cache_resp_t pending[$];
    int          errors;

    function new();
      idx_bits = 4'd12;
      errors = 0;
      foreach (valid[i]) valid[i] = 0;
      foreach (psel_bit[i]) psel_bit[i] = 0;
    endfunction

    function logic [11:0] mask_of();
      int b;
      b = (idx_bits > 12) ? 12 : idx_bits;
      return 12'((1 << b) - 1);
    endfunction

    function logic [31:0] rl(logic [31:0] x, int k);
      return (x << k) | (x >> (32 - k));
    endfunction

    function void mixer(ref logic [31:0] a, ref logic [31:0] b, ref logic [31:0] c);
      a -= c; a ^= rl(c, 4);  c += b;
      b -= a; b ^= rl(a, 6);  a += c;
      c -= b; c ^= rl(b, 8);  b += a;
      a -= c; a ^= rl(c, 16); c += b;
      b -= a; b ^= rl(a, 19); a += c;
      c -= b; c ^= rl(b, 4);  b += a;
    endfunction

    function logic [11:0] hash_index(logic [31:0] k[7], logic [30:0] ctx);
      logic [31:0] a, b, c;
      a = 32'hdeadbeef + {1'b0, ctx}; b = a; c = a;
      a += k[0]; b += k[1]; c += k[2];
      mixer(a, b, c);
      a += k[3]; b += k[4]; b += k[5];  // word 5 goes into b on purpose
      mixer(a, b, c);
      a += k[6];
      c ^= b; c -= rl(b, 14);
      a ^= c; a -= rl(c, 11);
      b ^= a; b -= rl(a, 25);
      c ^= b; c -= rl(b, 16);
      a ^= c; a -= rl(c, 4);
      b ^= a; b -= rl(a, 14);
      c ^= b; c -= rl(b, 24);
      return c[11:0] & mask_of();
    endfunction

    function bit way_hit(int w, logic [31:0] k[7], logic [30:0] ctx);
      if (!valid[w] || ctxs[w] != ctx) return 0;
      for (int i = 0; i < 7; i++) if (keys[w][i] != k[i]) return 0;
      return 1;
    endfunction

    function void note_request(logic [1:0] rt, logic [63:0] k01, logic [63:0] k23,
                               logic [63:0] k45, logic [31:0] k6, logic [30:0] ctx,
                               logic [11:0] slot, logic [63:0] p0, logic [63:0] p1,
                               logic [63:0] p2);
      cache_resp_t r;
      logic [31:0] k[7];
      int s, pw, sw;
      r = '0;
      k[0] = k01[31:0]; k[1] = k01[63:32]; k[2] = k23[31:0]; k[3] = k23[63:32];
      k[4] = k45[31:0]; k[5] = k45[63:32]; k[6] = k6;
      if (rt == REQ_LOOKUP) begin
        s = hash_index(k, ctx);
        r.set_index = 12'(s);
        pw = s * 2 + psel_bit[s];
        sw = s * 2 + (psel_bit[s] ^ 1);
        if (way_hit(pw, k, ctx)) r.hit = 1;
        else if (way_hit(sw, k, ctx)) begin
          r.hit = 1; psel_bit[s] ^= 1; pw = sw;
        end
        if (r.hit) begin
          r.data_lo = pay[pw][0]; r.data_mid = pay[pw][1]; r.data_hi = pay[pw][2];
        end
      end else if (rt == REQ_ADD) begin
        s = slot & mask_of();
        r.set_index = 12'(s);
        psel_bit[s] ^= 1;
        pw = s * 2 + psel_bit[s];
        valid[pw] = 1; ctxs[pw] = ctx;
        for (int i = 0; i < 7; i++) keys[pw][i] = k[i];
        pay[pw][0] = p0; pay[pw][1] = p1; pay[pw][2] = p2;
      end else if (rt == REQ_FLUSH) begin
        foreach (valid[i]) valid[i] = 0;
      end
      pending.push_back(r);
    endfunction

    function void check_response(cache_resp_t got);
      cache_resp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit != e.hit) begin
        $display("%0t: hit exp %h got %h", $realtime, e.hit, got.hit); errors++;
      end
      if (got.set_index != e.set_index) begin
        $display("%0t: set_index exp %h got %h", $realtime, e.set_index, got.set_index);
        errors++;
      end
      if (got.data_lo != e.data_lo) begin
        $display("%0t: data_lo exp %h got %h", $realtime, e.data_lo, got.data_lo); errors++;
      end
      if (got.data_mid != e.data_mid) begin
        $display("%0t: data_mid exp %h got %h", $realtime, e.data_mid, got.data_mid);
        errors++;
      end
      if (got.data_hi != e.data_hi) begin
        $display("%0t: data_hi exp %h got %h", $realtime, e.data_hi, got.data_hi); errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, hit, psel, penable, pwrite, pready;
  logic [1:0] req_type;
  logic [63:0] key_w01, key_w23, key_w45, payload_lo, payload_mid, payload_hi;
  logic [63:0] data_lo, data_mid, data_hi;
  logic [31:0] key_w6, pwdata, prdata;
  logic [30:0] context_req;
  logic [11:0] slot_index, set_index;
  logic [0:0] paddr;

  cache_scoreboard sb;

  // remembered keys, so lookups hit often
  logic [63:0] kq01[$], kq23[$], kq45[$];
  logic [31:0] kq6[$];
  logic [30:0] kqc[$];

  two_way_hashed_result_cache_core dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

  // the block cannot stall results: check each strobe as it comes
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_response({hit, set_index, data_lo, data_mid, data_hi});
  end

  task automatic write_index_bits(logic [3:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 1'b0; pwdata <= {28'd0, v};
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.idx_bits = v;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // wait for every expected transfer, plus the flush pass worth of margin
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4200) @(posedge clk);
  endtask

  // one request transfer, driven from the next falling edge
  task automatic send_req(logic [1:0] rt, logic [63:0] k01, logic [63:0] k23,
                          logic [63:0] k45, logic [31:0] k6, logic [30:0] ctx,
                          logic [11:0] slot, logic [63:0] p0, logic [63:0] p1,
                          logic [63:0] p2);
    @(negedge clk);
    start <= 1; req_type <= rt; key_w01 <= k01; key_w23 <= k23; key_w45 <= k45;
    key_w6 <= k6; context_req <= ctx; slot_index <= slot;
    payload_lo <= p0; payload_mid <= p1; payload_hi <= p2;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(rt, k01, k23, k45, k6, ctx, slot, p0, p1, p2);
    @(negedge clk);
    start <= 0;
  endtask

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_req();
    int pick, j;
    logic [63:0] k01, k23, k45;
    logic [31:0] k6;
    logic [30:0] ctx;
    pick = $urandom_range(99);
    k01 = r64(); k23 = r64(); k45 = r64(); k6 = $urandom; ctx = 31'($urandom);
    if (kq01.size() > 0 && pick < 60) begin
      j = $urandom_range(kq01.size() - 1);
      k01 = kq01[j]; k23 = kq23[j]; k45 = kq45[j]; k6 = kq6[j]; ctx = kqc[j];
      // occasionally disturb one word for a near miss
      if ($urandom_range(9) == 0) k45 ^= 64'(1) << $urandom_range(63);
      send_req(REQ_LOOKUP, k01, k23, k45, k6, ctx, 12'($urandom), r64(), r64(), r64());
    end else if (pick < 90) begin
      if (kq01.size() >= 64) begin
        void'(kq01.pop_front()); void'(kq23.pop_front()); void'(kq45.pop_front());
        void'(kq6.pop_front()); void'(kqc.pop_front());
      end
      kq01.push_back(k01); kq23.push_back(k23); kq45.push_back(k45);
      kq6.push_back(k6); kqc.push_back(ctx);
      // add into the set the lookup would hash to, mostly
      send_req(REQ_ADD, k01, k23, k45, k6, ctx,
               (pick < 85) ? 12'(sb.hash_index('{k01[31:0], k01[63:32], k23[31:0],
                   k23[63:32], k45[31:0], k45[63:32], k6}, ctx)) : 12'($urandom),
               r64(), r64(), r64());
    end else if (pick < 95) begin
      send_req(REQ_LOOKUP, k01, k23, k45, k6, ctx, 12'($urandom), r64(), r64(), r64());
    end else if (pick < 98) begin
      send_req(REQ_UNUSED, k01, k23, k45, k6, ctx, 12'($urandom), r64(), r64(), r64());
    end else begin
      send_req(REQ_FLUSH, k01, k23, k45, k6, ctx, 12'($urandom), r64(), r64(), r64());
    end
  endtask

  initial begin
    logic [63:0] ones;
    logic [3:0] settings[5];
    int left, gap;
    sb = new();
    ones = '1;
    settings = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd12};
    rst = 1; start = 0; req_type = REQ_LOOKUP; key_w01 = 0; key_w23 = 0; key_w45 = 0;
    key_w6 = 0; context_req = 0; slot_index = 0; payload_lo = 0; payload_mid = 0;
    payload_hi = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, every request kind, swap on secondary hit, flush
    send_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_ADD, 0, 0, 0, 0, 0, 12'hfff, ones, 0, ones);
    send_req(REQ_ADD, ones, ones, ones, '1, '1, 12'hfff, 0, ones, 0);
    send_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_LOOKUP, ones, ones, ones, '1, '1, 0, 0, 0, 0);
    send_req(REQ_ADD, 0, 0, 0, 0, 0, 12'(sb.hash_index('{0, 0, 0, 0, 0, 0, 0}, 0)),
             64'h1111, 64'h2222, 64'h3333);
    send_req(REQ_ADD, 1, 0, 0, 0, 0, 12'(sb.hash_index('{0, 0, 0, 0, 0, 0, 0}, 0)),
             64'h4, 64'h5, 64'h6);
    send_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_LOOKUP, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    send_req(REQ_UNUSED, ones, ones, ones, '1, '1, '1, ones, ones, ones);
    send_req(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // random phases over several index widths, extremes included
    foreach (settings[s]) begin
      write_index_bits(settings[s]);
      left = 80;
      while (left > 0) begin
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(8);
        repeat (gap) @(negedge clk);
        for (int b = $urandom_range(12, 1); b > 0 && left > 0; b--) begin
          random_req();
          left--;
        end
        // at most one hold-off, in the third phase, until everything has come back
        if (left == 40 && s == 2) while (sb.pending.size() != 0) @(negedge clk);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/thrc_pkg.sv
rtl/thrc_ram.sv
rtl/thrc_hash.sv
rtl/two_way_hashed_result_cache_core.sv
test/tb.sv
